// ===== src/gcte_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// gcte_pkg
// Shared types and constants of the granule chain table engine: map
// geometry, entry codes, request and result records, sequencer states.
// ---------------------------------------------------------------------------
package gcte_pkg;

  localparam int MAP_DEPTH     = 256;
  localparam int IDX_W         = $clog2(MAP_DEPTH);
  localparam int GRANULE_BYTES = 2304;
  localparam int K_W           = 9;
  localparam int MARK_W        = 9;
  localparam int MARK_LIMIT    = 256;
  localparam int ACC_W         = $clog2(MAP_DEPTH * GRANULE_BYTES + 1);

  localparam logic [7:0]  FREE_MARK  = 8'hFF;
  localparam logic [7:0]  TERM_LOW   = 8'hC0;
  localparam logic [7:0]  TERM_HIGH  = 8'hC9;
  localparam logic [7:0]  DIR_TRACK  = 8'd17;
  localparam logic [3:0]  ODD_SECTOR = 4'd10;
  localparam logic [3:0]  EVEN_SECTOR = 4'd1;
  localparam logic [19:0] COUNT_MAX  = 20'hFFFFF;
  localparam logic [7:0]  GIU_RESET  = 8'd68;

  localparam int O_FIRST_LSB = 28;
  localparam int O_LBC_LSB   = 36;
  localparam int O_SECT_LSB  = 53;

  typedef enum logic [2:0] {
    OP_LOAD       = 3'd0,
    OP_READ       = 3'd1,
    OP_MEASURE    = 3'd2,
    OP_FREE_SPACE = 3'd3,
    OP_ALLOCATE   = 3'd4,
    OP_FREE_CHAIN = 3'd5,
    OP_LOCATE     = 3'd6,
    OP_NONE       = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CORRUPT  = 2'd1,
    ST_NO_SPACE = 2'd2,
    ST_RAN_OUT  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_READ_WAIT,
    S_CNT_RD,
    S_CNT_CHK,
    S_ALLOC_RD,
    S_ALLOC_CHK,
    S_ALLOC_TERM,
    S_MEAS_RD,
    S_MEAS_CHK,
    S_MEAS_END,
    S_FREE_RD,
    S_FREE_CHK,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t         req_type;
    logic [7:0]  granule_index;
    logic [7:0]  entry_value;
    logic [15:0] last_sector_bytes;
    logic [19:0] file_size;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  read_value;
    logic [19:0] byte_count;
    logic [7:0]  first_granule;
    logic [8:0]  last_bytes_code;
    logic [7:0]  track_number;
    logic [3:0]  sector_number;
  } res_t;

  typedef struct packed {
    logic idle;
    logic done;
  } wlk_stat_t;

endpackage

`default_nettype wire

// ===== src/gcte_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// gcte_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ---------------------------------------------------------------------------
module gcte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire [$clog2(DEPTH)-1:0]   waddr,
  input  wire [WIDTH-1:0]           wdata,
  input  wire [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/gcte_walker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// gcte_walker
// Request sequencer with the granule map RAM and one shared accumulator.
// Walks chains, scans the map and writes links.
// ---------------------------------------------------------------------------
module gcte_walker (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  gcte_pkg::req_t      req,
  input  wire [7:0]           granules_in_use,
  input  wire                 res_take,
  output gcte_pkg::wlk_stat_t stat,
  output gcte_pkg::res_t      res
);
  import gcte_pkg::*;

  state_t          state, state_next;
  req_t            req_r, req_r_next;
  res_t            res_r, res_r_next;
  logic [K_W-1:0]  k, k_next;
  logic [MARK_W-1:0] m, m_next;
  logic [ACC_W-1:0] acc, acc_next;
  logic [19:0]     rem, rem_next;
  logic [7:0]      prev, prev_next;
  logic [7:0]      first, first_next;
  logic [7:0]      e_reg, e_reg_next;
  logic [7:0]      term, term_next;
  logic            have_prev, have_prev_next;
  logic            any_free, any_free_next;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [7:0]       rdata;

  logic [K_W-1:0] n;
  logic           k_lt_n, k_in_map, gi_in_map, rd_free, mark_full, e_ge_n;
  logic           rem_last, size_over, meas_ok, lsb_nz;
  logic [7:0]     e_val;
  logic [19:0]    rem_round;
  logic [7:0]     e_off;
  logic [31:0]    meas_sum;
  logic [7:0]     loc_half;

  gcte_ram #(.WIDTH(8), .DEPTH(MAP_DEPTH)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  assign n = ({1'b0, granules_in_use} < K_W'(MAP_DEPTH)) ? {1'b0, granules_in_use}
                                                         : K_W'(MAP_DEPTH);
  assign k_lt_n    = k < n;
  assign k_in_map  = k < K_W'(MAP_DEPTH);
  assign gi_in_map = {1'b0, req_r.granule_index} < K_W'(MAP_DEPTH);
  assign rd_free   = rdata == FREE_MARK;
  assign e_val     = k_in_map ? rdata : FREE_MARK;
  assign mark_full = m == MARK_W'(MARK_LIMIT);
  assign e_ge_n    = {1'b0, e_val} >= n;
  assign rem_last  = rem <= 20'(GRANULE_BYTES);
  assign rem_round = rem + 20'd255;
  assign size_over = 32'(req_r.file_size) > 32'(acc);
  assign lsb_nz    = req_r.last_sector_bytes != 16'd0;
  assign meas_ok   = (e_reg >= TERM_LOW) && (e_reg <= TERM_HIGH) &&
                     !((e_reg == TERM_LOW) && lsb_nz);
  assign e_off     = e_reg - TERM_LOW - {7'd0, lsb_nz};
  assign meas_sum  = 32'(acc) + 32'(req_r.last_sector_bytes) + {20'd0, e_off[3:0], 8'd0};
  assign loc_half  = {1'b0, req_r.granule_index[7:1]};

  assign stat.idle = state == S_IDLE;
  assign stat.done = state == S_DONE;
  assign res       = res_r;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:       if (start) state_next = S_EXEC;
      S_EXEC: begin
        case (req_r.req_type)
          OP_READ:       state_next = S_READ_WAIT;
          OP_MEASURE:    state_next = S_MEAS_RD;
          OP_FREE_SPACE: state_next = S_CNT_RD;
          OP_ALLOCATE:   state_next = S_CNT_RD;
          OP_FREE_CHAIN: state_next = S_FREE_RD;
          default:       state_next = S_DONE;
        endcase
      end
      S_READ_WAIT:  state_next = S_DONE;
      S_CNT_RD: begin
        if (k_lt_n) begin
          state_next = S_CNT_CHK;
        end else if (req_r.req_type == OP_ALLOCATE && !size_over && any_free) begin
          state_next = S_ALLOC_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_CNT_CHK:    state_next = S_CNT_RD;
      S_ALLOC_RD:   state_next = k_lt_n ? S_ALLOC_CHK : S_DONE;
      S_ALLOC_CHK: begin
        if (rd_free && rem_last) begin
          state_next = S_ALLOC_TERM;
        end else begin
          state_next = S_ALLOC_RD;
        end
      end
      S_ALLOC_TERM: state_next = S_DONE;
      S_MEAS_RD:    state_next = S_MEAS_CHK;
      S_MEAS_CHK: begin
        if (mark_full) begin
          state_next = S_DONE;
        end else if (e_ge_n) begin
          state_next = S_MEAS_END;
        end else begin
          state_next = S_MEAS_RD;
        end
      end
      S_MEAS_END:   state_next = S_DONE;
      S_FREE_RD:    state_next = k_lt_n ? S_FREE_CHK : S_DONE;
      S_FREE_CHK:   state_next = S_FREE_RD;
      S_DONE:       if (res_take) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_r_next     = req_r;
    res_r_next     = res_r;
    k_next         = k;
    m_next         = m;
    acc_next       = acc;
    rem_next       = rem;
    prev_next      = prev;
    first_next     = first;
    e_reg_next     = e_reg;
    term_next      = term;
    have_prev_next = have_prev;
    any_free_next  = any_free;
    ram_we         = 1'b0;
    ram_waddr      = k[IDX_W-1:0];
    ram_wdata      = FREE_MARK;
    ram_raddr      = k[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        if (start) req_r_next = req;
      end
      S_EXEC: begin
        res_r_next    = '0;
        k_next        = {1'b0, req_r.granule_index};
        m_next        = '0;
        acc_next      = '0;
        any_free_next = 1'b0;
        ram_raddr     = req_r.granule_index[IDX_W-1:0];
        case (req_r.req_type)
          OP_LOAD: begin
            ram_we    = gi_in_map;
            ram_waddr = req_r.granule_index[IDX_W-1:0];
            ram_wdata = req_r.entry_value;
          end
          OP_FREE_SPACE, OP_ALLOCATE: k_next = '0;
          OP_LOCATE: begin
            res_r_next.track_number  = (loc_half >= DIR_TRACK) ? loc_half + 8'd1 : loc_half;
            res_r_next.sector_number = req_r.granule_index[0] ? ODD_SECTOR : EVEN_SECTOR;
          end
          default: ;
        endcase
      end
      S_READ_WAIT: begin
        res_r_next.read_value = gi_in_map ? rdata : FREE_MARK;
      end
      S_CNT_RD: begin
        if (!k_lt_n) begin
          if (req_r.req_type == OP_FREE_SPACE) begin
            res_r_next.byte_count = 20'(acc);
          end else if (size_over) begin
            res_r_next.status = ST_NO_SPACE;
          end else if (!any_free) begin
            res_r_next.status = ST_RAN_OUT;
          end else begin
            k_next         = '0;
            have_prev_next = 1'b0;
            rem_next       = req_r.file_size;
          end
        end
      end
      S_CNT_CHK: begin
        if (rd_free) begin
          acc_next      = acc + ACC_W'(GRANULE_BYTES);
          any_free_next = 1'b1;
        end
        k_next = k + K_W'(1);
      end
      S_ALLOC_RD: begin
        if (!k_lt_n) res_r_next.status = ST_RAN_OUT;
      end
      S_ALLOC_CHK: begin
        if (rd_free) begin
          ram_we         = have_prev;
          ram_waddr      = prev[IDX_W-1:0];
          ram_wdata      = k[7:0];
          if (!have_prev) first_next = k[7:0];
          have_prev_next = 1'b1;
          prev_next      = k[7:0];
          if (rem_last) begin
            term_next = TERM_LOW + rem_round[15:8];
          end else begin
            rem_next = rem - 20'(GRANULE_BYTES);
            k_next   = k + K_W'(1);
          end
        end else begin
          k_next = k + K_W'(1);
        end
      end
      S_ALLOC_TERM: begin
        ram_we                     = 1'b1;
        ram_waddr                  = prev[IDX_W-1:0];
        ram_wdata                  = term;
        res_r_next.first_granule   = first;
        res_r_next.last_bytes_code =
          (req_r.file_size[7:0] == 8'd0 && req_r.file_size != 20'd0) ?
          9'd256 : {1'b0, req_r.file_size[7:0]};
      end
      S_MEAS_CHK: begin
        if (mark_full) begin
          res_r_next.status = ST_CORRUPT;
        end else if (e_ge_n) begin
          e_reg_next = e_val;
        end else begin
          m_next   = m + MARK_W'(1);
          acc_next = acc + ACC_W'(GRANULE_BYTES);
          k_next   = {1'b0, e_val};
        end
      end
      S_MEAS_END: begin
        if (!meas_ok) begin
          res_r_next.status = ST_CORRUPT;
        end else if (meas_sum > 32'(COUNT_MAX)) begin
          res_r_next.byte_count = COUNT_MAX;
        end else begin
          res_r_next.byte_count = meas_sum[19:0];
        end
      end
      S_FREE_CHK: begin
        ram_we    = 1'b1;
        ram_waddr = k[IDX_W-1:0];
        ram_wdata = FREE_MARK;
        k_next    = {1'b0, rdata};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    req_r     <= req_r_next;
    res_r     <= res_r_next;
    k         <= k_next;
    m         <= m_next;
    acc       <= acc_next;
    rem       <= rem_next;
    prev      <= prev_next;
    first     <= first_next;
    e_reg     <= e_reg_next;
    term      <= term_next;
    have_prev <= have_prev_next;
    any_free  <= any_free_next;
  end

endmodule

`default_nettype wire

// ===== src/granule_chain_table_engine_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// granule_chain_table_engine_core
// Granule allocation map with load, read, chain measure, free count,
// first-fit allocate, chain free and granule locate, one result per request.
// ---------------------------------------------------------------------------
// One request is taken at a time; s_axis_tready is low until the sequencer
// is back in idle. Every map entry visited takes a read address step, then
// a step on the registered read data and decision, on the map RAM. Allocate
// first runs the free-space scan, then scans entries up to the last granule
// taken. A finished result waits in the output register, so the next
// request is accepted while it is unread.
// ---------------------------------------------------------------------------
module granule_chain_table_engine_core (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // granule_index[7:0], entry_value[15:8], last_sector_bytes[31:16],
  // file_size[51:32], zero[55:52]
  input  wire [55:0]  s_axis_tdata,
  // req_type[2:0]
  input  wire [2:0]   s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // read_value[7:0], byte_count[27:8], first_granule[35:28],
  // last_bytes_code[44:36], track_number[52:45], sector_number[56:53],
  // zero[63:57]
  output logic [63:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]  m_axis_tuser,
  input  wire         cfg_wen,
  input  wire [7:0]   cfg_wdata
);
  import gcte_pkg::*;

  logic [7:0] granules_in_use;
  req_t       req;
  res_t       res;
  wlk_stat_t  stat;
  logic       start;
  logic       res_take;

  assign s_axis_tready = stat.idle;
  assign start         = s_axis_tvalid && s_axis_tready;
  assign res_take      = !m_axis_tvalid || m_axis_tready;

  assign req.req_type          = op_t'(s_axis_tuser);
  assign req.granule_index     = s_axis_tdata[7:0];
  assign req.entry_value       = s_axis_tdata[15:8];
  assign req.last_sector_bytes = s_axis_tdata[31:16];
  assign req.file_size         = s_axis_tdata[51:32];

  gcte_walker u_walker (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .req             (req),
    .granules_in_use (granules_in_use),
    .res_take        (res_take),
    .stat            (stat),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      granules_in_use <= GIU_RESET;
    end else if (cfg_wen) begin
      granules_in_use <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_take) begin
      m_axis_tvalid <= stat.done;
    end
    if (res_take && stat.done) begin
      m_axis_tdata <= {7'd0, res.sector_number, res.track_number, res.last_bytes_code,
                       res.first_granule, res.byte_count, res.read_value};
      m_axis_tuser <= res.status;
    end
  end

endmodule

`default_nettype wire

// ===== src/gcte_checker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// gcte_checker
// Port-level checks of the granule chain table engine, bound to the top.
// ---------------------------------------------------------------------------
module gcte_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire [55:0] s_axis_tdata,
  input wire [2:0]  s_axis_tuser,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [63:0] m_axis_tdata,
  input wire [1:0]  m_axis_tuser,
  input wire        cfg_wen,
  input wire [7:0]  cfg_wdata
);
  import gcte_pkg::*;

  logic [3:0] sect;
  logic [7:0] first_g;
  logic [8:0] lbc;

  assign sect    = m_axis_tdata[O_SECT_LSB +: 4];
  assign first_g = m_axis_tdata[O_FIRST_LSB +: 8];
  assign lbc     = m_axis_tdata[O_LBC_LSB +: 9];

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while previous one is in work");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
    (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != ST_OK) |->
    (first_g == 8'd0 && lbc == 9'd0 && sect == 4'd0))
    else $error("failed request carries allocation or locate fields");

  a_sector_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (sect == 4'd0 || sect == EVEN_SECTOR || sect == ODD_SECTOR))
    else $error("bad sector number");

endmodule

bind granule_chain_table_engine_core gcte_checker u_gcte_checker (.*);

`default_nettype wire
